// ----- src/gbta_pkg.sv -----
// Package for the greedy box-track association block: payload structs,
// result kinds, sequencer states and register indexes.
// No dependencies.
`default_nettype none
package gbta_pkg;

  localparam int unsigned MaxTracksDef = 32;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    KIND_MATCHED = 2'd0,
    KIND_NEW     = 2'd1,
    KIND_KEPT    = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_XFRAC = 2'd0,
    REG_YFRAC = 2'd1,
    REG_MISS  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_CHECK, ST_PLACE, ST_AGE, ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic              has_detection;
    logic [7:0]        object_class;
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_top;
    logic [CoordW-1:0] box_right;
    logic [CoordW-1:0] box_bottom;
    logic              frame_end;
  } det_req_t;

  typedef struct packed {
    logic [15:0]       track_id;
    logic [1:0]        result_kind;
    logic [7:0]        out_class;
    logic [CoordW-1:0] out_left;
    logic [CoordW-1:0] out_top;
    logic [CoordW-1:0] out_right;
    logic [CoordW-1:0] out_bottom;
    logic              last_of_run;
  } trk_res_t;

endpackage : gbta_pkg
`default_nettype wire

// ----- src/greedy_box_track_association.sv -----
// Greedy box-track association. Each request takes one detection and/or a
// frame end. A detection is accepted, then pending tracks are scanned
// newest to oldest (a search step registers the class check and the scale
// multiply, a check step compares), a track that is not pending is skipped
// in one search step, and one more search step leads to place or report; a
// frame end then ages and compacts every stored track; a last emit step
// returns the sequencer to idle. The pace is set by the single sequencer
// that walks the register-file track table, and the output hold register
// must release the last result before the next request starts; every
// output stall lengthens the run. A two-entry request queue lets the sender
// run ahead of the table walk. Results carry last_of_run on the final
// result of each request.
// Depends on gbta_pkg, gbta_front and gbta_back.
`default_nettype none
module greedy_box_track_association import gbta_pkg::*; #(
  parameter int unsigned MaxTracks = MaxTracksDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire det_req_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output trk_res_t                 out_data_o
);
  logic     q_valid, q_ready, b_valid, b_ready;
  logic     qb_valid, qb_ready;
  det_req_t q_data;
  trk_res_t b_data, hold_q;
  logic     hold_v_q;

  gbta_front #(.CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  gbta_back #(.MaxTracks(MaxTracks)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .q_valid_i(qb_valid), .q_ready_o(qb_ready), .q_data_i(q_data),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(b_data)
  );

  // Start the next request only once the held result has left
  assign qb_valid = q_valid && !hold_v_q;
  assign q_ready  = qb_ready && !hold_v_q;

  // Hold one result back until the next one (or idle) shows it is last
  logic back_idle;
  assign back_idle = qb_ready;
  assign b_ready = !hold_v_q || out_ready_i;
  assign out_valid_o = hold_v_q && (b_valid || back_idle);
  always_comb begin
    out_data_o = hold_q;
    out_data_o.last_of_run = !b_valid && back_idle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_v_q <= 1'b0;
    else if (b_valid && b_ready) hold_v_q <= 1'b1;
    else if (out_valid_o && out_ready_i) hold_v_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (b_valid && b_ready) hold_q <= b_data;
  end
endmodule : greedy_box_track_association
`default_nettype wire

// ----- src/gbta_front.sv -----
// Front part: takes requests, masks the box to the coordinate width and
// queues them in a two-entry buffer for the back part. Uses gbta_pkg.
`default_nettype none
module gbta_front import gbta_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire det_req_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output det_req_t      q_data_o
);
  localparam logic [CoordW-1:0] Mask = CoordW'((32'd1 << CoordBits) - 32'd1);

  det_req_t  buf_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  det_req_t  clean;

  // Mask: drop coordinate bits beyond the configured width
  always_comb begin
    clean = in_data_i;
    clean.box_left   = in_data_i.box_left & Mask;
    clean.box_top    = in_data_i.box_top & Mask;
    clean.box_right  = in_data_i.box_right & Mask;
    clean.box_bottom = in_data_i.box_bottom & Mask;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rd_q];

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= ~wr_q;
      if (q_valid_o && q_ready_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(q_valid_o && q_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) buf_q[wr_q] <= clean;
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("ready while full");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !q_valid_o) else $error("valid while empty");
`endif
endmodule : gbta_front
`default_nettype wire

// ----- src/gbta_back.sv -----
// Back part: sequencer over the track table. Searches newest to oldest,
// then appends if nothing matched, then ages and compacts at frame end. Uses gbta_pkg.
`default_nettype none
module gbta_back import gbta_pkg::*; #(
  parameter int unsigned MaxTracks = MaxTracksDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                q_valid_i,
  output logic                     q_ready_o,
  input  wire det_req_t            q_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output trk_res_t                 out_data_o
);
  localparam int unsigned IdxW = (MaxTracks > 1) ? $clog2(MaxTracks) : 1;
  localparam int unsigned CntW = $clog2(MaxTracks + 1);

  back_state_e state_q, state_d;

  logic [15:0] xfrac_q, yfrac_q;
  logic [7:0]  miss_lim_q;
  logic [15:0] next_id_q;
  logic        frame_open_q;
  logic [CntW-1:0] count_q;
  logic [MaxTracks-1:0] pend_q;

  logic [15:0]       id_q   [MaxTracks];
  logic [7:0]        cls_q  [MaxTracks];
  logic [CoordW-1:0] l_q [MaxTracks], t_q [MaxTracks], r_q [MaxTracks], b_q [MaxTracks];
  logic [8:0]        miss_q [MaxTracks];

  det_req_t        cur_q;
  logic [CntW-1:0] ptr_q;    // search: index+1; aging: read index
  logic [CntW-1:0] wptr_q;   // compaction write index
  trk_res_t        res_q;
  logic            res_v_q;

  logic [IdxW-1:0] si, ri, wi;
  assign si = IdxW'(ptr_q - CntW'(1));
  assign ri = ptr_q[IdxW-1:0];
  assign wi = wptr_q[IdxW-1:0];

  // Axis test, stage one: products registered before compare
  logic signed [13:0] dext_x, dext_y, text_x, text_y;
  logic [13:0] dcx, dcy, tcx, tcy, distx, disty;
  logic [13:0] mag_x, mag_y;
  logic [29:0] prod_x_q, prod_y_q;
  logic        negx_q, negy_q;
  logic signed [13:0] dext_x_q, dext_y_q;
  logic [13:0] distx_q, disty_q;
  logic        cls_ok_q;

  always_comb begin
    dext_x = $signed({2'b0, cur_q.box_right}) - $signed({2'b0, cur_q.box_left});
    dext_y = $signed({2'b0, cur_q.box_bottom}) - $signed({2'b0, cur_q.box_top});
    text_x = $signed({2'b0, r_q[si]}) - $signed({2'b0, l_q[si]});
    text_y = $signed({2'b0, b_q[si]}) - $signed({2'b0, t_q[si]});
    dcx = ({2'b0, cur_q.box_left} + {2'b0, cur_q.box_right}) >> 1;
    dcy = ({2'b0, cur_q.box_top} + {2'b0, cur_q.box_bottom}) >> 1;
    tcx = ({2'b0, l_q[si]} + {2'b0, r_q[si]}) >> 1;
    tcy = ({2'b0, t_q[si]} + {2'b0, b_q[si]}) >> 1;
    distx = (dcx > tcx) ? dcx - tcx : tcx - dcx;
    disty = (dcy > tcy) ? dcy - tcy : tcy - dcy;
    mag_x = text_x[13] ? 14'(-text_x) : 14'(text_x);
    mag_y = text_y[13] ? 14'(-text_y) : 14'(text_y);
  end

  // Axis test, stage two: floor scaling and compare against registered products
  logic signed [15:0] lim_x, lim_y;
  always_comb begin
    lim_x = negx_q ? -$signed({2'b0, 14'((prod_x_q + 30'd65535) >> 16)})
                   : $signed({2'b0, 14'(prod_x_q >> 16)});
    lim_y = negy_q ? -$signed({2'b0, 14'((prod_y_q + 30'd65535) >> 16)})
                   : $signed({2'b0, 14'(prod_y_q >> 16)});
    if (16'(dext_x_q) < lim_x) lim_x = 16'(dext_x_q);
    if (16'(dext_y_q) < lim_y) lim_y = 16'(dext_y_q);
  end
  logic match_hit;
  assign match_hit = cls_ok_q && ($signed({2'b0, distx_q}) <= lim_x)
                              && ($signed({2'b0, disty_q}) <= lim_y);

  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;
  assign q_ready_o   = (state_q == ST_IDLE) && !res_v_q;

  logic res_free;
  assign res_free = !res_v_q || out_ready_i;

  // Load the result register when a match, a placement or a kept track reports
  logic age_emit, res_load;
  assign age_emit = (ptr_q != count_q) && pend_q[ri] &&
                    (miss_q[ri] <= {1'b0, miss_lim_q}) && res_free;
  always_comb begin
    case (state_q)
      ST_CHECK: res_load = match_hit && res_free;
      ST_PLACE: res_load = res_free;
      ST_AGE:   res_load = age_emit;
      default:  res_load = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (q_valid_i && q_ready_o) state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (!cur_q.has_detection) state_d = cur_q.frame_end ? ST_AGE : ST_EMIT;
        else if (ptr_q == '0) state_d = ST_PLACE;
        else if (pend_q[si]) state_d = ST_CHECK;
      end
      ST_CHECK:  if (match_hit) begin
        if (res_free) state_d = cur_q.frame_end ? ST_AGE : ST_EMIT;
      end else state_d = ST_SEARCH;
      ST_PLACE:  if (res_free) state_d = cur_q.frame_end ? ST_AGE : ST_EMIT;
      ST_AGE:    if (ptr_q == count_q) state_d = ST_EMIT;
      ST_EMIT:   if (res_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Datapath and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xfrac_q <= 16'd52429;
      yfrac_q <= 16'd52429;
      miss_lim_q <= 8'd1;
      next_id_q <= 16'd1;
      frame_open_q <= 1'b0;
      count_q <= '0;
      pend_q <= '0;
      res_v_q <= 1'b0;
      ptr_q <= '0;
      wptr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_XFRAC: xfrac_q <= cfg_wdata_i;
          REG_YFRAC: yfrac_q <= cfg_wdata_i;
          REG_MISS:  miss_lim_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (res_load) res_v_q <= 1'b1;
      else if (out_ready_i) res_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (q_valid_i && q_ready_o) begin
          ptr_q <= count_q;
          if (!frame_open_q) begin
            for (int k = 0; k < MaxTracks; k++) pend_q[k] <= (CntW'(k) < count_q);
            frame_open_q <= 1'b1;
          end
        end
        ST_SEARCH: begin
          if (!cur_q.has_detection) begin
            ptr_q <= '0;
            wptr_q <= '0;
          end else if (ptr_q != '0 && !pend_q[si]) ptr_q <= ptr_q - CntW'(1);
        end
        ST_CHECK: begin
          if (match_hit) begin
            if (res_free) begin
              l_q[si] <= cur_q.box_left;  t_q[si] <= cur_q.box_top;
              r_q[si] <= cur_q.box_right; b_q[si] <= cur_q.box_bottom;
              miss_q[si] <= '0;
              pend_q[si] <= 1'b0;
              res_q <= '{id_q[si], KIND_MATCHED, cur_q.object_class, cur_q.box_left,
                         cur_q.box_top, cur_q.box_right, cur_q.box_bottom, 1'b0};
              ptr_q <= '0;
              wptr_q <= '0;
            end
          end else ptr_q <= ptr_q - CntW'(1);
        end
        ST_PLACE: if (res_free) begin
          if (count_q < CntW'(MaxTracks)) begin
            id_q[count_q[IdxW-1:0]] <= next_id_q;
            cls_q[count_q[IdxW-1:0]] <= cur_q.object_class;
            l_q[count_q[IdxW-1:0]] <= cur_q.box_left;
            t_q[count_q[IdxW-1:0]] <= cur_q.box_top;
            r_q[count_q[IdxW-1:0]] <= cur_q.box_right;
            b_q[count_q[IdxW-1:0]] <= cur_q.box_bottom;
            miss_q[count_q[IdxW-1:0]] <= '0;
            pend_q[count_q[IdxW-1:0]] <= 1'b0;
            count_q <= count_q + CntW'(1);
            next_id_q <= next_id_q + 16'd1;
            res_q <= '{next_id_q, KIND_NEW, cur_q.object_class, cur_q.box_left,
                       cur_q.box_top, cur_q.box_right, cur_q.box_bottom, 1'b0};
          end else begin
            res_q <= '{16'd0, KIND_FULL, cur_q.object_class, cur_q.box_left,
                       cur_q.box_top, cur_q.box_right, cur_q.box_bottom, 1'b0};
          end
          ptr_q <= '0;
          wptr_q <= '0;
        end
        ST_AGE: begin
          if (ptr_q == count_q) begin
            count_q <= wptr_q;
            pend_q <= '0;
            frame_open_q <= 1'b0;
          end else if (pend_q[ri] && miss_q[ri] > {1'b0, miss_lim_q}) begin
            ptr_q <= ptr_q + CntW'(1);   // remove: skip without copying
          end else if (!pend_q[ri] || res_free) begin
            id_q[wi] <= id_q[ri];
            cls_q[wi] <= cls_q[ri];
            l_q[wi] <= l_q[ri]; t_q[wi] <= t_q[ri];
            r_q[wi] <= r_q[ri]; b_q[wi] <= b_q[ri];
            miss_q[wi] <= pend_q[ri] ? miss_q[ri] + 9'd1 : miss_q[ri];
            if (pend_q[ri]) begin
              res_q <= '{id_q[ri], KIND_KEPT, cls_q[ri], l_q[ri], t_q[ri],
                         r_q[ri], b_q[ri], 1'b0};
            end
            ptr_q <= ptr_q + CntW'(1);
            wptr_q <= wptr_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the request and the registered products
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) cur_q <= q_data_i;
    prod_x_q <= 30'(mag_x) * 30'(xfrac_q);
    prod_y_q <= 30'(mag_y) * 30'(yfrac_q);
    negx_q <= text_x[13];
    negy_q <= text_y[13];
    dext_x_q <= dext_x;
    dext_y_q <= dext_y;
    distx_q <= distx;
    disty_q <= disty;
    cls_ok_q <= (cls_q[si] == cur_q.object_class);
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxTracks)) else $error("track count beyond table");
  a_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_AGE |-> wptr_q <= ptr_q) else $error("compaction overtook read");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> !res_v_q) else $error("accept while result held");
`endif
endmodule : gbta_back
`default_nettype wire
